FILE: rtl/core/aebp_pkg.sv
// Shared types, widths and constants for the azimuth/elevation CORDIC block.
package aebp_pkg;

  localparam int POS_W        = 24;
  localparam int ANG_W        = 16;
  localparam int DIFF_W       = POS_W + 1;
  localparam int GUARD        = 12;
  localparam int CW           = 40;
  localparam int ZW           = 34;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int RND_SHIFT    = 32 - ANG_W;

  localparam logic [29:0] INV_GAIN = 30'h26DD3B6A;
  localparam logic signed [ZW-1:0] INT_HALF_PI = ZW'(64'sh40000000);
  localparam logic signed [ZW-1:0] RND_HALF    = ZW'(64'sd1 <<< (RND_SHIFT - 1));
  localparam logic signed [ZW-1:0] OUT_HALF    = ZW'(64'sd1 <<< (ANG_W - 1));
  localparam logic signed [ZW-1:0] OUT_QUARTER = ZW'(64'sd1 <<< (ANG_W - 2));

  typedef struct packed {
    logic signed [POS_W-1:0] from_x;
    logic signed [POS_W-1:0] from_y;
    logic signed [POS_W-1:0] from_z;
    logic signed [POS_W-1:0] to_x;
    logic signed [POS_W-1:0] to_y;
    logic signed [POS_W-1:0] to_z;
  } in_t;

  typedef struct packed {
    logic signed [ANG_W:0]   azimuth;
    logic signed [ANG_W-1:0] elevation;
    logic                    no_horizontal_offset;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // carried alongside the horizontal vectoring
  typedef struct packed {
    logic signed [DIFF_W-1:0] dz;
    logic                     flat;
  } side1_t;

  // carried alongside the vertical vectoring
  typedef struct packed {
    logic signed [ANG_W:0] az;
    logic                  flat;
    logic                  dz_pos;
    logic                  dz_neg;
  } side2_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(34'sh020000000);
      1:  a = ZW'(34'sh012E4051E);
      2:  a = ZW'(34'sh009FB385B);
      3:  a = ZW'(34'sh0051111D4);
      4:  a = ZW'(34'sh0028B0D43);
      5:  a = ZW'(34'sh00145D7E1);
      6:  a = ZW'(34'sh000A2F61E);
      7:  a = ZW'(34'sh000517C55);
      8:  a = ZW'(34'sh00028BE53);
      9:  a = ZW'(34'sh000145F2F);
      10: a = ZW'(34'sh0000A2F98);
      11: a = ZW'(34'sh0000517CC);
      12: a = ZW'(34'sh000028BE6);
      13: a = ZW'(34'sh0000145F3);
      14: a = ZW'(34'sh00000A2FA);
      15: a = ZW'(34'sh00000517D);
      16: a = ZW'(34'sh0000028BE);
      17: a = ZW'(34'sh00000145F);
      18: a = ZW'(34'sh000000A30);
      19: a = ZW'(34'sh000000518);
      20: a = ZW'(34'sh00000028C);
      21: a = ZW'(34'sh000000146);
      22: a = ZW'(34'sh0000000A3);
      23: a = ZW'(34'sh000000051);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/aebp_cell.sv
// One CORDIC vectoring iteration with its pipeline register and sideband.
module aebp_cell
  import aebp_pkg::*;
#(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vec_t              in_vec,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output vec_t              out_vec,
  output logic [SIDE_W-1:0] out_side
);

  localparam logic signed [ZW-1:0] ANGLE = atan_step(STEP);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  vec_t                 vec_next;

  assign xs = in_vec.x >>> STEP;
  assign ys = in_vec.y >>> STEP;

  always_comb begin
    if (!in_vec.y[CW-1]) begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + ANGLE;
    end else begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec  <= vec_next;
      out_side <= in_side;
    end
  end

endmodule

FILE: rtl/core/aebp_gain.sv
// Gain correction of the horizontal magnitude and azimuth finish, two stages.
module aebp_gain
  import aebp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  vec_t   in_vec,
  input  side1_t in_side,
  output logic   out_valid,
  output vec_t   out_vec,
  output side2_t out_side
);

  localparam int HI_W  = CW - 16;
  localparam int PH_W  = HI_W + 30;
  localparam int PL_W  = 15 + 30;
  localparam int SUM_W = PH_W + 1;

  logic signed [CW-1:0] h;
  logic [HI_W-1:0]      hi;
  logic [14:0]          lo;
  logic signed [ZW-1:0] rz;
  logic signed [ZW-1:0] az_raw;
  logic signed [ZW-1:0] az_wrap;
  logic signed [ZW-1:0] az_clamp;

  // stage one
  logic            s1_valid;
  logic [PH_W-1:0] p_hi;
  logic [PL_W-1:0] p_lo;
  side1_t          s1_side;
  logic signed [ANG_W:0] s1_az;

  logic [SUM_W-1:0]       sum;
  logic signed [CW-1:0]   hc;
  logic signed [CW-1:0]   dz_s;

  assign h  = in_vec.x[CW-1] ? '0 : in_vec.x;
  assign hi = h[CW-2:15];
  assign lo = h[14:0];

  assign rz     = (in_vec.z + RND_HALF) >>> RND_SHIFT;
  assign az_raw = OUT_QUARTER - rz;

  always_comb begin
    az_wrap = (az_raw > OUT_HALF) ? az_raw - (OUT_HALF <<< 1) : az_raw;
    if (az_wrap > OUT_HALF) begin
      az_clamp = OUT_HALF;
    end else if (az_wrap < -OUT_HALF) begin
      az_clamp = -OUT_HALF;
    end else begin
      az_clamp = az_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi    <= PH_W'(hi) * PH_W'(INV_GAIN);
      p_lo    <= PL_W'(lo) * PL_W'(INV_GAIN);
      s1_side <= in_side;
      s1_az   <= az_clamp[ANG_W:0];
    end
  end

  assign sum  = SUM_W'(p_hi) + SUM_W'(p_lo[PL_W-1:15]);
  assign hc   = CW'(sum >> 15);
  assign dz_s = {{(CW-DIFF_W-GUARD){s1_side.dz[DIFF_W-1]}}, s1_side.dz, {GUARD{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec.x       <= hc;
      out_vec.y       <= dz_s;
      out_vec.z       <= '0;
      out_side.az     <= s1_az;
      out_side.flat   <= s1_side.flat;
      out_side.dz_pos <= !s1_side.dz[DIFF_W-1] && (s1_side.dz != '0);
      out_side.dz_neg <= s1_side.dz[DIFF_W-1];
    end
  end

endmodule

FILE: rtl/core/aebp_out.sv
// Elevation finish, output register and skid stage.
module aebp_out
  import aebp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   res_valid,
  input  vec_t   res_vec,
  input  side2_t res_side,
  output logic   en,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  logic signed [ZW-1:0] rz;
  logic signed [ZW-1:0] el_raw;
  logic signed [ZW-1:0] el_clamp;
  out_t                 res;
  logic                 skid_valid;
  out_t                 skid;
  logic                 out_free;
  logic                 take;

  assign rz     = (res_vec.z + RND_HALF) >>> RND_SHIFT;
  assign el_raw = -rz;

  always_comb begin
    if (el_raw > OUT_QUARTER) begin
      el_clamp = OUT_QUARTER;
    end else if (el_raw < -OUT_QUARTER) begin
      el_clamp = -OUT_QUARTER;
    end else begin
      el_clamp = el_raw;
    end
    res.no_horizontal_offset = res_side.flat;
    if (res_side.flat) begin
      res.azimuth = OUT_QUARTER[ANG_W:0];
      if (res_side.dz_pos) begin
        res.elevation = -OUT_QUARTER[ANG_W-1:0];
      end else if (res_side.dz_neg) begin
        res.elevation = OUT_QUARTER[ANG_W-1:0];
      end else begin
        res.elevation = '0;
      end
    end else begin
      res.azimuth   = res_side.az;
      res.elevation = el_clamp[ANG_W-1:0];
    end
  end

  assign en       = !skid_valid;
  assign out_free = !out_valid || out_ready;
  assign take     = en && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_data <= skid;
      end
    end else if (take) begin
      if (out_free) begin
        out_data <= res;
      end else begin
        skid <= res;
      end
    end
  end

endmodule

FILE: rtl/core/azimuth_elevation_between_points_top.sv
// Top level: azimuth and elevation between two points by pipelined CORDIC.
//
// Input channel in_valid/in_ready/in_data carries one point pair per
// transaction; output channel out_valid/out_ready/out_data returns azimuth
// (clockwise from north), elevation and the no-horizontal-offset flag.
// Every transaction in gives exactly one transaction out, in order.
// Datapath: difference and quadrant stage, CORDIC_STEPS cells of horizontal
// vectoring, two gain-correction stages, CORDIC_STEPS cells of vertical
// vectoring, then the output register. One transaction is accepted per cycle
// while the pipeline is not held by the skid stage.
// in_ready depends only on the skid stage: while a result waits in the
// output register the pipeline keeps moving; once a second result lands in
// the skid stage the whole pipeline holds and in_ready drops until the
// receiver takes the waiting result.
// Reset clears every valid bit; the pipeline is empty afterwards.
module azimuth_elevation_between_points_top
  import aebp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int S1W = $bits(side1_t);
  localparam int S2W = $bits(side2_t);

  logic                     en;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic signed [CW-1:0]     sx;
  logic signed [CW-1:0]     sy;
  vec_t                     pre_vec;
  side1_t                   pre_side;

  logic   v1  [0:CORDIC_STEPS];
  vec_t   c1  [0:CORDIC_STEPS];
  side1_t s1  [0:CORDIC_STEPS];
  logic   v2  [0:CORDIC_STEPS];
  vec_t   c2  [0:CORDIC_STEPS];
  side2_t s2  [0:CORDIC_STEPS];

  assign in_ready = en;

  assign dx = DIFF_W'(in_data.to_x) - DIFF_W'(in_data.from_x);
  assign dy = DIFF_W'(in_data.to_y) - DIFF_W'(in_data.from_y);
  assign dz = DIFF_W'(in_data.to_z) - DIFF_W'(in_data.from_z);
  assign sx = {{(CW-DIFF_W-GUARD){dx[DIFF_W-1]}}, dx, {GUARD{1'b0}}};
  assign sy = {{(CW-DIFF_W-GUARD){dy[DIFF_W-1]}}, dy, {GUARD{1'b0}}};

  // quarter turn into the right half-plane
  always_comb begin
    if (!sx[CW-1]) begin
      pre_vec.x = sx;
      pre_vec.y = sy;
      pre_vec.z = '0;
    end else if (!sy[CW-1]) begin
      pre_vec.x = sy;
      pre_vec.y = -sx;
      pre_vec.z = INT_HALF_PI;
    end else begin
      pre_vec.x = -sy;
      pre_vec.y = sx;
      pre_vec.z = -INT_HALF_PI;
    end
    pre_side.dz   = dz;
    pre_side.flat = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1[0] <= 1'b0;
    end else if (en) begin
      v1[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= pre_vec;
      s1[0] <= pre_side;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_horiz
    logic [S1W-1:0] side_q;
    aebp_cell #(
      .STEP   (i),
      .SIDE_W (S1W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v1[i]),
      .in_vec    (c1[i]),
      .in_side   (s1[i]),
      .out_valid (v1[i+1]),
      .out_vec   (c1[i+1]),
      .out_side  (side_q)
    );
    assign s1[i+1] = side1_t'(side_q);
  end

  aebp_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1[CORDIC_STEPS]),
    .in_vec    (c1[CORDIC_STEPS]),
    .in_side   (s1[CORDIC_STEPS]),
    .out_valid (v2[0]),
    .out_vec   (c2[0]),
    .out_side  (s2[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vert
    logic [S2W-1:0] side_q;
    aebp_cell #(
      .STEP   (i),
      .SIDE_W (S2W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v2[i]),
      .in_vec    (c2[i]),
      .in_side   (s2[i]),
      .out_valid (v2[i+1]),
      .out_vec   (c2[i+1]),
      .out_side  (side_q)
    );
    assign s2[i+1] = side2_t'(side_q);
  end

  aebp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (v2[CORDIC_STEPS]),
    .res_vec   (c2[CORDIC_STEPS]),
    .res_side  (s2[CORDIC_STEPS]),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: verif/tb.sv
// Testbench for the azimuth/elevation block: directed and random point pairs checked against a CORDIC predictor.
module tb
  import aebp_pkg::*;
();

  localparam int HOLD_CYCLES = 2 * CORDIC_STEPS_DEF + 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PAIRS = 1030;
  localparam longint ANG_HALF = longint'(1) << (ANG_W - 1);
  localparam longint ANG_QUARTER = longint'(1) << (ANG_W - 2);
  localparam longint Z_HALF_PI = 64'h40000000;
  localparam longint GAIN_INV_Q30 = 64'h26DD3B6A;
  localparam int ROUND_SHIFT = 32 - ANG_W;
  localparam int SCALE_BITS = 12;
  localparam logic signed [POS_W-1:0] P_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] P_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t point_pairs[$];
  out_t angles_due[$];
  out_t want;
  int err_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  logic steady;

  // atan(2^-i), units of pi/2^31
  longint atan_lut [0:23] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  azimuth_elevation_between_points_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign steady = (sent_count >= 400) && (sent_count < 650);

  function automatic longint vector_angle(longint x0, longint y0, output longint mag);
    longint x, y, z, xs, ys, t;
    int steps;
    x = x0;
    y = y0;
    z = 0;
    steps = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = Z_HALF_PI;
      end else begin
        x = -y;
        y = t;
        z = -Z_HALF_PI;
      end
    end
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_lut[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_lut[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint round_angle(longint v);
    return (v + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  endfunction

  function automatic out_t aim_angles(in_t pp);
    longint dx, dy, dz, h, hc, spare, a, e, az, el;
    out_t r;
    dx = longint'(pp.to_x) - longint'(pp.from_x);
    dy = longint'(pp.to_y) - longint'(pp.from_y);
    dz = longint'(pp.to_z) - longint'(pp.from_z);
    a = vector_angle(dx <<< SCALE_BITS, dy <<< SCALE_BITS, h);
    if (h < 0) h = 0;
    // undo the CORDIC gain in two halves to stay inside 64 bits
    hc = ((h >> 15) * GAIN_INV_Q30 + (((h & 64'h7FFF) * GAIN_INV_Q30) >> 15)) >> 15;
    e = vector_angle(hc, dz <<< SCALE_BITS, spare);
    az = ANG_QUARTER - round_angle(a);
    if (az > ANG_HALF) az = az - 2 * ANG_HALF;
    if (az > ANG_HALF) az = ANG_HALF;
    if (az < -ANG_HALF) az = -ANG_HALF;
    el = -round_angle(e);
    if (el > ANG_QUARTER) el = ANG_QUARTER;
    if (el < -ANG_QUARTER) el = -ANG_QUARTER;
    r.no_horizontal_offset = (dx == 0) && (dy == 0);
    if (r.no_horizontal_offset) begin
      az = ANG_QUARTER;
      el = (dz > 0) ? -ANG_QUARTER : ((dz < 0) ? ANG_QUARTER : 0);
    end
    r.azimuth = az[ANG_W:0];
    r.elevation = el[ANG_W-1:0];
    return r;
  endfunction

  function automatic in_t pair(logic signed [POS_W-1:0] fx, logic signed [POS_W-1:0] fy,
                               logic signed [POS_W-1:0] fz, logic signed [POS_W-1:0] tx,
                               logic signed [POS_W-1:0] ty, logic signed [POS_W-1:0] tz);
    in_t pp;
    pp.from_x = fx;
    pp.from_y = fy;
    pp.from_z = fz;
    pp.to_x = tx;
    pp.to_y = ty;
    pp.to_z = tz;
    return pp;
  endfunction

  function automatic logic signed [POS_W-1:0] nudge(logic signed [POS_W-1:0] p, int span);
    int off;
    off = int'($urandom_range(2 * span)) - span;
    return p + POS_W'(off);
  endfunction

  task automatic queue_pair(in_t pp);
    point_pairs = {point_pairs, pp};
  endtask

  task automatic note_error(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(string name, longint got, longint exp_val);
    if (got != exp_val) note_error($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  // driver: input transactions, prediction at acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        angles_due = {angles_due, aim_angles(in_data)};
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (point_pairs.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          in_valid <= 1'b1;
          in_data <= point_pairs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: output transactions
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 30);
      if (out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          note_error("result with nothing outstanding");
        end else begin
          want = angles_due.pop_front();
          check_field("azimuth", $signed(out_data.azimuth), $signed(want.azimuth));
          check_field("elevation", $signed(out_data.elevation), $signed(want.elevation));
          check_field("no_horizontal_offset", out_data.no_horizontal_offset,
                      want.no_horizontal_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("azimuth_elevation_between_points_top verification failed");
      $finish;
    end
  end

  initial begin
    in_t pp;
    int kind;
    int total_pairs;
    // directed: flat cases, field extremes, quadrant edges, steep slopes
    queue_pair(pair(0, 0, 0, 0, 0, 0));
    queue_pair(pair(100, -200, 0, 100, -200, 5));
    queue_pair(pair(P_MIN, P_MAX, P_MAX, P_MIN, P_MAX, P_MIN));
    queue_pair(pair(P_MAX, P_MIN, P_MIN, P_MAX, P_MIN, P_MAX));
    queue_pair(pair(P_MIN, 0, 0, P_MAX, 0, 0));
    queue_pair(pair(P_MAX, 0, 0, P_MIN, 0, 0));
    queue_pair(pair(0, P_MIN, 0, 0, P_MAX, 0));
    queue_pair(pair(0, P_MAX, 0, 0, P_MIN, 0));
    queue_pair(pair(0, 0, 0, -1, 0, 0));
    queue_pair(pair(0, 0, 0, 1, 0, 0));
    queue_pair(pair(0, 0, 0, 0, -1, 0));
    queue_pair(pair(0, 0, 0, 0, 1, 0));
    queue_pair(pair(0, 0, 0, -1000, -1, 0));
    queue_pair(pair(0, 0, 0, -1000, 1, 0));
    queue_pair(pair(0, 0, P_MIN, 1, 0, P_MAX));
    queue_pair(pair(0, 0, P_MAX, 1, 0, P_MIN));
    queue_pair(pair(0, 0, P_MIN, 0, -1, P_MAX));
    queue_pair(pair(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX));
    queue_pair(pair(P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN));
    queue_pair(pair(P_MAX, P_MIN, 0, P_MIN, P_MAX, 0));
    queue_pair(pair(0, 0, 0, 1, 1, 1));
    queue_pair(pair(-5, 7, 3, -6, 6, 2));
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      kind = $urandom_range(9);
      pp = pair(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      case (kind)
        5, 6: begin
          pp.to_x = nudge(pp.from_x, 64);
          pp.to_y = nudge(pp.from_y, 64);
          pp.to_z = nudge(pp.from_z, 64);
        end
        7: begin
          pp.to_x = pp.from_x;
          pp.to_y = pp.from_y;
          if ($urandom_range(3) == 0) pp.to_z = pp.from_z;
        end
        8: begin
          if ($urandom_range(1) == 0) pp.to_x = pp.from_x;
          else pp.to_y = pp.from_y;
        end
        9: begin
          pp.to_x = nudge(pp.from_x, 1 << 20);
          pp.to_y = nudge(pp.from_y, 1 << 20);
          pp.to_z = nudge(pp.from_z, 1 << 22);
        end
        default: ;
      endcase
      queue_pair(pp);
    end
    total_pairs = point_pairs.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (sent_count < total_pairs || angles_due.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("azimuth_elevation_between_points_top verification clean");
    end else begin
      $display("azimuth_elevation_between_points_top verification failed");
    end
    $finish;
  end

endmodule
